FILE: hw/rtl/fprp_pkg.sv
// ----------------------------------------------------------------------------
// fprp_pkg
// Shared types and constants of the flame ring pixel mapper.
// ----------------------------------------------------------------------------
package fprp_pkg;

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_WINDOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_REACH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_DIM   = 3'd4;

	localparam logic [7:0] RST_INNER_RADIUS = 8'd40;
	localparam logic [7:0] RST_OUTER_RADIUS = 8'd80;
	localparam logic [7:0] RST_ANGLE_WINDOW = 8'd30;
	localparam logic [7:0] RST_RADIUS_REACH = 8'd40;
	localparam logic [7:0] RST_CENTER_DIM   = 8'd20;

	localparam int ANGLE_FULL = 360;
	localparam int ANGLE_HALF = 180;

	// x / 5 = (x * 205) >> 10 and x / 10 = (x * 205) >> 11 for x up to 255
	localparam logic [15:0] RECIP_205  = 16'd205;
	localparam int          SHIFT_DIV5  = 10;
	localparam int          SHIFT_DIV10 = 11;

	localparam int LED_W = 5;
	localparam int DVD_W = 12;
	localparam int DVS_W = 9;

	typedef struct packed {
		logic [8:0] theta;
		logic [7:0] radius;
		logic [7:0] bright;
		logic       dim;
	} item_t;

	typedef struct packed {
		logic [7:0] inner_radius;
		logic [7:0] outer_radius;
		logic [7:0] window;
		logic [7:0] reach;
		logic [7:0] dim_radius;
	} cfg_t;

	typedef struct packed {
		logic [LED_W-1:0] led;
		logic             last;
	} tag_t;

endpackage

FILE: hw/rtl/fprp_front.sv
// ----------------------------------------------------------------------------
// fprp_front
// Accepts flame points, folds the angle into 0..359 and flags center dimming.
// ----------------------------------------------------------------------------
module fprp_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [8:0]            flame_angle,
	input  logic [7:0]            flame_radius,
	input  logic [7:0]            flame_brightness,
	input  fprp_pkg::cfg_t        cfg,
	input  logic                  q_full,
	output logic                  q_push,
	output fprp_pkg::item_t       q_item
);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.theta  = (flame_angle >= 9'(fprp_pkg::ANGLE_FULL)) ?
			flame_angle - 9'(fprp_pkg::ANGLE_FULL) : flame_angle;
		q_item.radius = flame_radius;
		q_item.bright = flame_brightness;
		q_item.dim    = flame_radius > cfg.dim_radius;
	end

endmodule

FILE: hw/rtl/fprp_queue.sv
// ----------------------------------------------------------------------------
// fprp_queue
// Two-entry queue between the front and the LED sequencer.
// ----------------------------------------------------------------------------
module fprp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fprp_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output fprp_pkg::item_t head_item
);

	fprp_pkg::item_t data_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_item  = data_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			data_q[wr_q] <= push_item;
	end

endmodule

FILE: hw/rtl/fprp_div.sv
// ----------------------------------------------------------------------------
// fprp_div
// Pipelined restoring divider, one quotient bit per stage, stalls as a whole.
// ----------------------------------------------------------------------------
module fprp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [fprp_pkg::DVD_W-1:0]    dividend,
	input  logic [fprp_pkg::DVS_W-1:0]    divisor,
	input  fprp_pkg::tag_t                tag_in,
	output logic                          out_valid,
	output logic [fprp_pkg::DVD_W-1:0]    quotient,
	output fprp_pkg::tag_t                tag_out
);

	localparam int N  = fprp_pkg::DVD_W;
	localparam int RW = fprp_pkg::DVS_W;

	logic           v_s   [0:N];
	logic [RW-1:0]  rem_s [0:N];
	logic [N-1:0]   dq_s  [0:N];
	logic [RW-1:0]  dvs_s [0:N];
	fprp_pkg::tag_t tag_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			dq_s[0]  <= dividend;
			dvs_s[0] <= divisor;
			tag_s[0] <= tag_in;
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_step
		logic [RW:0] trial;
		logic        fits;

		// shift in the next dividend bit, quotient bits fill dq from the bottom
		assign trial = {rem_s[g], dq_s[g][N-1]};
		assign fits  = trial >= {1'b0, dvs_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= fits ? RW'(trial - {1'b0, dvs_s[g]}) : trial[RW-1:0];
				dq_s[g+1]  <= {dq_s[g][N-2:0], fits};
				dvs_s[g+1] <= dvs_s[g];
				tag_s[g+1] <= tag_s[g];
			end
		end
	end

	assign out_valid = v_s[N];
	assign quotient  = dq_s[N];
	assign tag_out   = tag_s[N];

endmodule

FILE: hw/rtl/fprp_back.sv
// ----------------------------------------------------------------------------
// fprp_back
// LED sequencer and color pipeline: one LED per cycle from the queue head while the output is not stalled.
// ----------------------------------------------------------------------------
module fprp_back #(
	parameter int INNER_COUNT = 8,
	parameter int OUTER_COUNT = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fprp_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	input  fprp_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fprp_pkg::LED_W-1:0]    led_index,
	output logic [7:0]                    red_level,
	output logic [5:0]                    green_level,
	output logic [4:0]                    white_level,
	output logic                          last_led
);

	localparam int TOTAL = 1 + INNER_COUNT + OUTER_COUNT;
	localparam int IDX_W = $clog2(TOTAL);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TOTAL - 1);
	localparam logic [IDX_W-1:0] IDX_INNER = IDX_W'(INNER_COUNT);
	localparam logic [8:0] STEP_IN  = 9'(360 / INNER_COUNT);
	localparam logic [8:0] STEP_OUT = 9'(360 / OUTER_COUNT);

	logic en;
	logic issue;

	// sequencer
	logic [IDX_W-1:0] idx_q;
	logic [8:0]       ang_q;
	logic             idx_last;

	// stage 1
	logic             v_s1, last_s1, ctr_s1, dim_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [8:0]       theta_s1, ang_s1;
	logic [7:0]       radius_s1, bright_s1, ringr_s1;
	logic [8:0]       diff, fold;
	logic [8:0]       reach_sum;
	logic [7:0]       ang_dist;
	logic             lit;
	logic [7:0]       rdist;

	// stage 2
	logic             v_s2, last_s2, ctr_s2, dim_s2, lit_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [7:0]       radius_s2, bright_s2, d_s2, rd_s2;
	logic [15:0]      ft_full, fr_full;
	logic [4:0]       ft, fr;

	// stage 3
	logic             v_s3, last_s3, ctr_s3, dim_s3, lit_s3;
	logic [IDX_W-1:0] idx_s3;
	logic [7:0]       radius_s3, bright_s3;
	logic [4:0]       ft_s3, fr_s3;
	logic [8:0]       prod;
	logic [fprp_pkg::DVD_W-1:0] bright_x10;
	logic [fprp_pkg::DVD_W-1:0] dvd;
	logic [fprp_pkg::DVS_W-1:0] dvs;
	fprp_pkg::tag_t   tag;

	// stage 4 into the divider
	logic             v_s4;
	logic [fprp_pkg::DVD_W-1:0] dvd_s4;
	logic [fprp_pkg::DVS_W-1:0] dvs_s4;
	fprp_pkg::tag_t   tag_s4;

	logic                       div_valid;
	logic [fprp_pkg::DVD_W-1:0] div_quot;
	fprp_pkg::tag_t             div_tag;
	logic [7:0]                 red;
	logic [15:0]                red_scaled;

	logic                       out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign issue    = en && q_valid;
	assign idx_last = idx_q == IDX_LAST;
	assign q_pop    = issue && idx_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ang_q <= '0;
		end else if (issue) begin
			if (idx_last)
				idx_q <= '0;
			else
				idx_q <= idx_q + IDX_W'(1);
			if (idx_q == '0)
				ang_q <= STEP_IN;
			else if (idx_q == IDX_INNER)
				ang_q <= STEP_OUT;
			else if (idx_q < IDX_INNER)
				ang_q <= ang_q + STEP_IN;
			else
				ang_q <= ang_q + STEP_OUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1    <= idx_q;
			last_s1   <= idx_last;
			ctr_s1    <= idx_q == '0;
			dim_s1    <= q_item.dim;
			theta_s1  <= q_item.theta;
			radius_s1 <= q_item.radius;
			bright_s1 <= q_item.bright;
			// a ring LED at a full turn sits at zero degrees
			ang_s1    <= (ang_q == 9'(fprp_pkg::ANGLE_FULL)) ? '0 : ang_q;
			ringr_s1  <= (idx_q <= IDX_INNER) ? cfg.inner_radius : cfg.outer_radius;
		end
	end

	// circular angle distance and reach test
	always_comb begin
		diff      = (ang_s1 >= theta_s1) ? ang_s1 - theta_s1 : theta_s1 - ang_s1;
		fold      = (diff > 9'(fprp_pkg::ANGLE_HALF)) ?
			9'(fprp_pkg::ANGLE_FULL) - diff : diff;
		ang_dist  = fold[7:0];
		reach_sum = {1'b0, radius_s1} + {1'b0, cfg.reach};
		lit       = (ang_dist < cfg.window) && ({1'b0, ringr_s1} < reach_sum);
		rdist     = (ringr_s1 >= radius_s1) ? ringr_s1 - radius_s1 : radius_s1 - ringr_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2    <= idx_s1;
			last_s2   <= last_s1;
			ctr_s2    <= ctr_s1;
			dim_s2    <= dim_s1;
			lit_s2    <= lit;
			radius_s2 <= radius_s1;
			bright_s2 <= bright_s1;
			d_s2      <= ang_dist;
			rd_s2     <= rdist;
		end
	end

	// both factors divided by ten, zero taken as one
	always_comb begin
		ft_full = {8'd0, d_s2} * fprp_pkg::RECIP_205;
		fr_full = {8'd0, rd_s2} * fprp_pkg::RECIP_205;
		ft      = 5'(ft_full >> fprp_pkg::SHIFT_DIV10);
		fr      = 5'(fr_full >> fprp_pkg::SHIFT_DIV10);
		if (ft == 5'd0)
			ft = 5'd1;
		if (fr == 5'd0)
			fr = 5'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3    <= idx_s2;
			last_s3   <= last_s2;
			ctr_s3    <= ctr_s2;
			dim_s3    <= dim_s2;
			lit_s3    <= lit_s2;
			radius_s3 <= radius_s2;
			bright_s3 <= bright_s2;
			ft_s3     <= ft;
			fr_s3     <= fr;
		end
	end

	// pick dividend and divisor; unlit LEDs divide zero by one
	always_comb begin
		prod       = {4'd0, ft_s3} * {4'd0, fr_s3};
		bright_x10 = ({4'd0, bright_s3} << 3) + ({4'd0, bright_s3} << 1);
		if (ctr_s3 && dim_s3) begin
			dvd = bright_x10;
			dvs = {1'b0, radius_s3};
		end else if (ctr_s3 || lit_s3) begin
			dvd = {4'd0, bright_s3};
			dvs = ctr_s3 ? 9'd1 : prod;
		end else begin
			dvd = '0;
			dvs = 9'd1;
		end
		tag.led  = fprp_pkg::LED_W'(idx_s3);
		tag.last = last_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s4 <= dvd;
			dvs_s4 <= dvs;
			tag_s4 <= tag;
		end
	end

	fprp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.dividend  (dvd_s4),
		.divisor   (dvs_s4),
		.tag_in    (tag_s4),
		.out_valid (div_valid),
		.quotient  (div_quot),
		.tag_out   (div_tag)
	);

	// saturate the dimmed center, then derive green and white
	always_comb begin
		red        = (div_quot > 12'd255) ? 8'd255 : div_quot[7:0];
		red_scaled = {8'd0, red} * fprp_pkg::RECIP_205;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			led_index   <= div_tag.led;
			last_led    <= div_tag.last;
			red_level   <= red;
			green_level <= 6'(red_scaled >> fprp_pkg::SHIFT_DIV5);
			white_level <= 5'(red_scaled >> fprp_pkg::SHIFT_DIV10);
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/flame_position_to_ring_pixels.sv
// ----------------------------------------------------------------------------
// flame_position_to_ring_pixels
// Maps a polar flame point onto a center LED and two concentric LED rings.
// ----------------------------------------------------------------------------
// Each accepted flame point produces 1 + INNER_COUNT + OUTER_COUNT output
// transactions (21 at the defaults), one per LED in LED order, last_led set on
// the final one. The LED sequencer emits one LED per cycle while the output is
// not stalled; a two-entry queue lets the next points be accepted while the
// current one is still being emitted. On its way out each LED passes the color
// stages and the twelve-stage pipelined divider.
module flame_position_to_ring_pixels #(
	parameter int INNER_COUNT = 8,
	parameter int OUTER_COUNT = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [fprp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [8:0]                        flame_angle,
	input  logic [7:0]                        flame_radius,
	input  logic [7:0]                        flame_brightness,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [4:0]                        led_index,
	output logic [7:0]                        red_level,
	output logic [5:0]                        green_level,
	output logic [4:0]                        white_level,
	output logic                              last_led
);

	fprp_pkg::cfg_t  cfg_q;
	logic            q_full;
	logic            q_push;
	fprp_pkg::item_t push_item;
	logic            q_pop;
	logic            head_valid;
	fprp_pkg::item_t head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inner_radius <= fprp_pkg::RST_INNER_RADIUS;
			cfg_q.outer_radius <= fprp_pkg::RST_OUTER_RADIUS;
			cfg_q.window       <= fprp_pkg::RST_ANGLE_WINDOW;
			cfg_q.reach        <= fprp_pkg::RST_RADIUS_REACH;
			cfg_q.dim_radius   <= fprp_pkg::RST_CENTER_DIM;
		end else if (cfg_write) begin
			case (cfg_index)
				fprp_pkg::REG_INNER_RADIUS: cfg_q.inner_radius <= cfg_data;
				fprp_pkg::REG_OUTER_RADIUS: cfg_q.outer_radius <= cfg_data;
				fprp_pkg::REG_ANGLE_WINDOW: cfg_q.window       <= cfg_data;
				fprp_pkg::REG_RADIUS_REACH: cfg_q.reach        <= cfg_data;
				fprp_pkg::REG_CENTER_DIM:   cfg_q.dim_radius   <= cfg_data;
				default: ;
			endcase
		end
	end

	fprp_front u_front (
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.flame_angle      (flame_angle),
		.flame_radius     (flame_radius),
		.flame_brightness (flame_brightness),
		.cfg              (cfg_q),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_item           (push_item)
	);

	fprp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	fprp_back #(
		.INNER_COUNT (INNER_COUNT),
		.OUTER_COUNT (OUTER_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (head_valid),
		.q_item      (head_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.led_index   (led_index),
		.red_level   (red_level),
		.green_level (green_level),
		.white_level (white_level),
		.last_led    (last_led)
	);

endmodule

FILE: hw/rtl/fprp_checker.sv
// ----------------------------------------------------------------------------
// fprp_checker
// Port-level checks of LED ordering, point framing, color derivation and stall hold.
// ----------------------------------------------------------------------------
module fprp_checker #(
	parameter int INNER_COUNT = 8,
	parameter int OUTER_COUNT = 12
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] led_index,
	input logic [7:0] red_level,
	input logic [5:0] green_level,
	input logic [4:0] white_level,
	input logic       last_led
);

	localparam int TOTAL = 1 + INNER_COUNT + OUTER_COUNT;
	localparam int CW    = $clog2(TOTAL + 1);

	logic          in_acc;
	logic          out_acc;
	logic [CW-1:0] exp_q;
	logic [3:0]    open_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// expected LED number and points accepted but not finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= '0;
			open_q <= '0;
		end else begin
			if (out_acc)
				exp_q <= last_led ? '0 : exp_q + CW'(1);
			if (in_acc && !(out_acc && last_led))
				open_q <= open_q + 4'd1;
			else if (!in_acc && out_acc && last_led)
				open_q <= open_q - 4'd1;
		end
	end

	a_led_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> led_index == 5'(exp_q))
		else $error("led_index out of sequence");

	a_last_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (last_led == (exp_q == CW'(TOTAL - 1))))
		else $error("last_led not on the final LED of a point");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_led |-> open_q != 4'd0)
		else $error("point finished without an accepted input");

	a_colors: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (9'(green_level) * 9'd5 <= 9'(red_level))
			&& (9'(red_level) < 9'(green_level) * 9'd5 + 9'd5)
			&& (9'(white_level) * 9'd10 <= 9'(red_level))
			&& (9'(red_level) < 9'(white_level) * 9'd10 + 9'd10))
		else $error("green or white not derived from red");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(led_index)
			&& $stable(red_level) && $stable(last_led))
		else $error("output changed while stalled");

endmodule

bind flame_position_to_ring_pixels fprp_checker #(
	.INNER_COUNT (INNER_COUNT),
	.OUTER_COUNT (OUTER_COUNT)
) u_fprp_checker (.*);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flame ring pixel mapper. Flame points go in on
// a valid/ready channel; every LED color that comes out is compared with a
// local prediction of the center and ring levels under the current register
// settings. A directed table comes first, then random points, most of them
// aimed near ring LEDs, over several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int INNER_COUNT = 8;
	localparam int OUTER_COUNT = 12;
	localparam int LED_TOTAL = 1 + INNER_COUNT + OUTER_COUNT;
	localparam int DIM_SCALE = 10;
	localparam int LEVEL_MAX = 255;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_PHASES = 6;
	localparam int POINTS_PER_PHASE = 44;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [4:0] led;
		logic [7:0] red;
		logic [5:0] green;
		logic [4:0] white;
		logic       last;
	} pixel_t;

	typedef struct packed {
		fprp_pkg::cfg_t cfg;
		logic [8:0] angle;
		logic [7:0] radius;
		logic [7:0] bright;
		logic       typed;
		logic [7:0] red;
		logic [5:0] green;
		logic [4:0] white;
	} point_row_t;

	localparam fprp_pkg::cfg_t CFG_RESET = '{fprp_pkg::RST_INNER_RADIUS,
		fprp_pkg::RST_OUTER_RADIUS, fprp_pkg::RST_ANGLE_WINDOW,
		fprp_pkg::RST_RADIUS_REACH, fprp_pkg::RST_CENTER_DIM};
	localparam fprp_pkg::cfg_t CFG_ZERO = '0;
	localparam fprp_pkg::cfg_t CFG_FULL = '1;
	localparam fprp_pkg::cfg_t CFG_HALF = '{8'd0, 8'd255, 8'd180, 8'd0, 8'd254};

	// typed rows carry the center LED color, the rest is predicted
	localparam point_row_t DIRECTED [22] = '{
		'{CFG_RESET, 9'd0,   8'd0,   8'd255, 1'b1, 8'd255, 6'd51, 5'd25},
		'{CFG_RESET, 9'd0,   8'd0,   8'd0,   1'b1, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd360, 8'd255, 8'd255, 1'b1, 8'd10,  6'd2,  5'd1},
		'{CFG_RESET, 9'd511, 8'd21,  8'd255, 1'b1, 8'd121, 6'd24, 5'd12},
		'{CFG_RESET, 9'd20,  8'd20,  8'd200, 1'b1, 8'd200, 6'd40, 5'd20},
		'{CFG_RESET, 9'd100, 8'd21,  8'd1,   1'b1, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd45,  8'd40,  8'd255, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd350, 8'd45,  8'd255, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd5,   8'd75,  8'd180, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd15,  8'd60,  8'd255, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd180, 8'd128, 8'd100, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd256, 8'd100, 8'd77,  1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd359, 8'd0,   8'd255, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_RESET, 9'd30,  8'd80,  8'd255, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_ZERO,  9'd90,  8'd1,   8'd255, 1'b1, 8'd255, 6'd51, 5'd25},
		'{CFG_ZERO,  9'd0,   8'd0,   8'd255, 1'b1, 8'd255, 6'd51, 5'd25},
		'{CFG_FULL,  9'd0,   8'd255, 8'd255, 1'b1, 8'd255, 6'd51, 5'd25},
		'{CFG_FULL,  9'd170, 8'd0,   8'd1,   1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_FULL,  9'd300, 8'd128, 8'd255, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_HALF,  9'd0,   8'd255, 8'd255, 1'b1, 8'd10,  6'd2,  5'd1},
		'{CFG_HALF,  9'd180, 8'd10,  8'd255, 1'b0, 8'd0,   6'd0,  5'd0},
		'{CFG_HALF,  9'd90,  8'd5,   8'd170, 1'b0, 8'd0,   6'd0,  5'd0}
	};

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           cfg_write = 1'b0;
	logic [fprp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                     cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [8:0]                     flame_angle = '0;
	logic [7:0]                     flame_radius = '0;
	logic [7:0]                     flame_brightness = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [4:0]                     led_index;
	logic [7:0]                     red_level;
	logic [5:0]                     green_level;
	logic [4:0]                     white_level;
	logic                           last_led;

	// travels with the payload: typed center color of the current point
	logic                 center_typed = 1'b0;
	pixel_t               center_known = '0;

	fprp_pkg::cfg_t model_cfg = CFG_RESET;
	pixel_t led_expect [$];
	int     send_gap_pct = 0;
	int     recv_gap_pct = 0;
	int     error_count = 0;
	int     points_done = 0;
	int     leds_checked = 0;
	int     settings_used = 0;
	int     stall_cycles = 0;

	flame_position_to_ring_pixels #(
		.INNER_COUNT(INNER_COUNT),
		.OUTER_COUNT(OUTER_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.flame_angle(flame_angle),
		.flame_radius(flame_radius),
		.flame_brightness(flame_brightness),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_index(led_index),
		.red_level(red_level),
		.green_level(green_level),
		.white_level(white_level),
		.last_led(last_led)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pixel_t make_pixel(input int slot, input int red);
		pixel_t p;
		p.led = 5'(slot);
		p.red = 8'(red);
		p.green = 6'(red / 5);
		p.white = 5'(red / 10);
		p.last = (slot == LED_TOTAL - 1);
		return p;
	endfunction

	function automatic int ring_red(input int led_ang, input int ring_r, input int theta,
		input int rad, input int bri);
		int a;
		int d;
		int rd;
		int ft;
		int fr;
		a = led_ang % fprp_pkg::ANGLE_FULL;
		d = (a >= theta) ? a - theta : theta - a;
		// circular distance across the 0/360 seam
		if (d > fprp_pkg::ANGLE_HALF)
			d = fprp_pkg::ANGLE_FULL - d;
		if (d >= int'(model_cfg.window))
			return 0;
		if (ring_r >= rad + int'(model_cfg.reach))
			return 0;
		rd = (ring_r >= rad) ? ring_r - rad : rad - ring_r;
		ft = d / 10;
		fr = rd / 10;
		if (ft == 0)
			ft = 1;
		if (fr == 0)
			fr = 1;
		return bri / (ft * fr);
	endfunction

	task automatic predict_point(input logic [8:0] angle, input logic [7:0] radius,
		input logic [7:0] bright, input logic typed, input pixel_t known);
		int theta;
		int rad;
		int bri;
		int ctr;
		int red;
		pixel_t p;
		theta = int'(angle) % fprp_pkg::ANGLE_FULL;
		rad = int'(radius);
		bri = int'(bright);
		if (rad > int'(model_cfg.dim_radius)) begin
			ctr = DIM_SCALE * bri / rad;
			if (ctr > LEVEL_MAX)
				ctr = LEVEL_MAX;
		end else begin
			ctr = bri;
		end
		p = make_pixel(0, ctr);
		if (typed) begin
			p.red = known.red;
			p.green = known.green;
			p.white = known.white;
		end
		led_expect.push_back(p);
		for (int slot = 1; slot < LED_TOTAL; slot++) begin
			if (slot <= INNER_COUNT)
				red = ring_red(slot * (fprp_pkg::ANGLE_FULL / INNER_COUNT),
					int'(model_cfg.inner_radius), theta, rad, bri);
			else
				red = ring_red((slot - INNER_COUNT) * (fprp_pkg::ANGLE_FULL / OUTER_COUNT),
					int'(model_cfg.outer_radius), theta, rad, bri);
			led_expect.push_back(make_pixel(slot, red));
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < MAX_PRINTED)
			$display("%0t mismatch on %s: got %0d, want %0d (led transaction %0d)",
				$realtime, what, got, want, leds_checked);
		error_count++;
	endtask

	// both channels plus the stall watchdog, all on sampled values
	always @(posedge clk) begin
		pixel_t want;
		logic moved;
		moved = 1'b0;
		if (arst_n && in_valid && in_ready) begin
			predict_point(flame_angle, flame_radius, flame_brightness, center_typed, center_known);
			points_done++;
			moved = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			moved = 1'b1;
			leds_checked++;
			if (led_expect.size() == 0) begin
				report_mismatch("unexpected led", int'(led_index), -1);
			end else begin
				want = led_expect.pop_front();
				if (led_index !== want.led)
					report_mismatch("led_index", int'(led_index), int'(want.led));
				if (red_level !== want.red)
					report_mismatch("red_level", int'(red_level), int'(want.red));
				if (green_level !== want.green)
					report_mismatch("green_level", int'(green_level), int'(want.green));
				if (white_level !== want.white)
					report_mismatch("white_level", int'(white_level), int'(want.white));
				if (last_led !== want.last)
					report_mismatch("last_led", int'(last_led), int'(want.last));
			end
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= (int'($urandom_range(0, 99)) >= recv_gap_pct);

	function automatic void pick_idling(input int mode);
		case (mode)
		0: begin
			send_gap_pct = 33;
			recv_gap_pct = 88;
		end
		1: begin
			send_gap_pct = 88;
			recv_gap_pct = 33;
		end
		default: begin
			send_gap_pct = 0;
			recv_gap_pct = 0;
		end
		endcase
	endfunction

	// called at a rising edge; returns at the edge that took the transaction
	task automatic send_point(input logic [8:0] angle, input logic [7:0] radius,
		input logic [7:0] bright, input logic typed, input pixel_t known);
		if (int'($urandom_range(0, 99)) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (int'($urandom_range(0, 99)) < send_gap_pct);
		end
		in_valid <= 1'b1;
		flame_angle <= angle;
		flame_radius <= radius;
		flame_brightness <= bright;
		center_typed <= typed;
		center_known <= known;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		do @(posedge clk); while (led_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fprp_pkg::CFG_IDX_W-1:0] idx,
		input logic [7:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
		fprp_pkg::REG_INNER_RADIUS: model_cfg.inner_radius = value;
		fprp_pkg::REG_OUTER_RADIUS: model_cfg.outer_radius = value;
		fprp_pkg::REG_ANGLE_WINDOW: model_cfg.window = value;
		fprp_pkg::REG_RADIUS_REACH: model_cfg.reach = value;
		fprp_pkg::REG_CENTER_DIM:   model_cfg.dim_radius = value;
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_settings(input fprp_pkg::cfg_t c);
		write_reg(fprp_pkg::REG_INNER_RADIUS, c.inner_radius);
		write_reg(fprp_pkg::REG_OUTER_RADIUS, c.outer_radius);
		write_reg(fprp_pkg::REG_ANGLE_WINDOW, c.window);
		write_reg(fprp_pkg::REG_RADIUS_REACH, c.reach);
		write_reg(fprp_pkg::REG_CENTER_DIM, c.dim_radius);
		// indexes past the register list must leave the settings alone
		for (int idx = int'(fprp_pkg::REG_CENTER_DIM) + 1; idx < 2 ** fprp_pkg::CFG_IDX_W;
			idx++)
			write_reg(fprp_pkg::CFG_IDX_W'(idx), 8'($urandom));
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	initial begin
		fprp_pkg::cfg_t rc;
		pixel_t known;
		int ang;
		int rad;
		int n;
		int ring_r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pick_idling(0);
		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (i == 0 || DIRECTED[i].cfg != model_cfg) begin
				settle_block();
				load_settings(DIRECTED[i].cfg);
			end
			known = '{5'd0, DIRECTED[i].red, DIRECTED[i].green, DIRECTED[i].white, 1'b0};
			send_point(DIRECTED[i].angle, DIRECTED[i].radius, DIRECTED[i].bright,
				DIRECTED[i].typed, known);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_block();
			rc.inner_radius = 8'($urandom_range(0, 255));
			rc.outer_radius = 8'($urandom_range(0, 255));
			rc.window = (phase == 3) ? 8'($urandom_range(181, 255)) : 8'($urandom_range(0, 180));
			rc.reach = 8'($urandom_range(0, 255));
			rc.dim_radius = 8'($urandom_range(0, 255));
			load_settings(rc);
			pick_idling(phase % 3);
			repeat (POINTS_PER_PHASE) begin
				if ($urandom_range(0, 2) == 0) begin
					ang = int'($urandom_range(0, 511));
					rad = int'($urandom_range(0, 255));
				end else begin
					// aim near one ring LED so that the lit branch gets exercised
					if ($urandom_range(0, 1) == 1) begin
						n = INNER_COUNT;
						ring_r = int'(model_cfg.inner_radius);
					end else begin
						n = OUTER_COUNT;
						ring_r = int'(model_cfg.outer_radius);
					end
					ang = int'($urandom_range(1, n)) * (fprp_pkg::ANGLE_FULL / n)
						+ int'($urandom_range(0, 60)) - 30;
					ang = (ang % fprp_pkg::ANGLE_FULL + fprp_pkg::ANGLE_FULL)
						% fprp_pkg::ANGLE_FULL;
					if (ang < 2 ** 9 - fprp_pkg::ANGLE_FULL && $urandom_range(0, 3) == 0)
						ang += fprp_pkg::ANGLE_FULL;
					rad = ring_r + int'($urandom_range(0, 60)) - 30;
					if (rad < 0)
						rad = 0;
					if (rad > 255)
						rad = 255;
				end
				send_point(9'(ang), 8'(rad), 8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (led_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d flame points under %0d register settings", points_done,
			settings_used);
		$display("%0d led transactions checked, %0d mismatches", leds_checked, error_count);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
